FILE: hw/rtl/aes_enc_pkg.sv
`timescale 1ns / 1ps
package aes_enc_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned RkWords   = 60;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  typedef enum logic [2:0] {
    CFG_KEY_SIZE = 3'd0,
    CFG_KEY_0    = 3'd1,
    CFG_KEY_1    = 3'd2,
    CFG_KEY_2    = 3'd3,
    CFG_KEY_3    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2,
    KEY_RSV = 2'd3
  } key_size_e;

  typedef enum logic {
    KS_IDLE,
    KS_RUN
  } ks_state_e;

  localparam logic [7:0] GfPoly = 8'h1b;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  // byte j of the state sits at bits 127-8j, column c holds bytes 4c..4c+3
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[4*c+j] = Sbox[s[127-8*(4*((c+j)%4)+j) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int j = 0; j < 4; j++) begin
        m[4*c+j] = t[4*c+j] ^ all ^ gf_double(t[4*c+j] ^ t[4*c+((j+1)%4)]);
      end
    end
    for (int b = 0; b < 16; b++) begin
      r[127-8*b -: 8] = (last ? t[b] : m[b]) ^ rk[127-8*b -: 8];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/aes_block_encrypt_top.sv
`timescale 1ns / 1ps
// channel   direction  payload    handshake
// input     in         aes_in_t   in_valid_i / in_stall_o
// output    out        aes_out_t  out_valid_o / out_stall_i
// config    in         64 bits    cfg_we_i, cfg_idx_i
//
// one block enters per cycle while in_stall_o is low; the pipeline holds an initial key add
// stage plus 14 round stages, rounds beyond the key's count pass through
// after reset or any key write, the schedule unit expands 44, 52 or 60 words, one per
// cycle, and input stalls until it is done
// output stall freezes the whole pipeline while a result waits, nothing is dropped or repeated
module aes_block_encrypt_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  aes_enc_pkg::aes_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output aes_enc_pkg::aes_out_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [63:0]           cfg_data_i
);
  import aes_enc_pkg::*;

  key_size_e   key_size_q;
  logic [63:0] key_q [4];
  logic        sched_q;
  logic        cfg_hit;

  ks_state_e   ks_state_q, ks_state_d;
  logic [5:0]  cnt_q;
  logic [2:0]  mod_q;
  logic [7:0]  rc_q;
  logic [31:0] win_q [8];
  logic [31:0] rk_q [RkWords];
  logic [31:0] ks_word, ks_temp;
  logic [2:0]  nk_m1;
  logic [3:0]  nr;
  logic [5:0]  ks_last;
  logic        ks_done;

  logic [127:0] st_q [NumRounds+1];
  logic         v_q [NumRounds+1];
  logic         advance, in_acc;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_KEY_SIZE || cfg_idx_i == CFG_KEY_0 ||
                   cfg_idx_i == CFG_KEY_1 || cfg_idx_i == CFG_KEY_2 || cfg_idx_i == CFG_KEY_3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= KEY_128;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_SIZE: key_size_q <= (cfg_data_i[1:0] == KEY_RSV) ? KEY_256
                                    : key_size_e'(cfg_data_i[1:0]);
        CFG_KEY_0: key_q[0] <= cfg_data_i;
        CFG_KEY_1: key_q[1] <= cfg_data_i;
        CFG_KEY_2: key_q[2] <= cfg_data_i;
        CFG_KEY_3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (key_size_q)
      KEY_128: begin nk_m1 = 3'd3; nr = 4'd10; ks_last = 6'd43; end
      KEY_192: begin nk_m1 = 3'd5; nr = 4'd12; ks_last = 6'd51; end
      default: begin nk_m1 = 3'd7; nr = 4'd14; ks_last = 6'd59; end
    endcase
  end

  // key schedule: one word per cycle, win_q[0] is the newest word
  always_comb begin
    ks_temp = win_q[0];
    if (mod_q == 3'd0) begin
      ks_temp = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
    end else if (nk_m1 == 3'd7 && mod_q == 3'd4) begin
      ks_temp = sub_word(win_q[0]);
    end
    if (cnt_q <= {3'd0, nk_m1}) begin
      ks_word = cnt_q[0] ? key_q[cnt_q[2:1]][31:0] : key_q[cnt_q[2:1]][63:32];
    end else begin
      ks_word = win_q[nk_m1] ^ ks_temp;
    end
  end

  assign ks_done = (ks_state_q == KS_RUN) && (cnt_q == ks_last);

  always_comb begin
    ks_state_d = ks_state_q;
    unique case (ks_state_q)
      KS_IDLE: if (!sched_q && !cfg_hit) ks_state_d = KS_RUN;
      KS_RUN:  if (cfg_hit || ks_done) ks_state_d = KS_IDLE;
      default: ks_state_d = KS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_state_q <= KS_IDLE;
      sched_q    <= 1'b0;
      cnt_q      <= '0;
      mod_q      <= '0;
      rc_q       <= 8'h01;
    end else begin
      ks_state_q <= ks_state_d;
      if (cfg_hit) sched_q <= 1'b0;
      else if (ks_done) sched_q <= 1'b1;
      if (ks_state_q == KS_RUN) begin
        cnt_q <= cnt_q + 6'd1;
        mod_q <= (mod_q == nk_m1) ? 3'd0 : mod_q + 3'd1;
        if (cnt_q > {3'd0, nk_m1} && mod_q == 3'd0) rc_q <= gf_double(rc_q);
      end else begin
        cnt_q <= '0;
        mod_q <= '0;
        rc_q  <= 8'h01;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ks_state_q == KS_RUN) begin
      rk_q[cnt_q] <= ks_word;
      win_q[0]    <= ks_word;
      for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
    end
  end

  // round pipeline
  assign advance    = !(v_q[NumRounds] && out_stall_i);
  assign in_stall_o = !advance || !sched_q || (ks_state_q == KS_RUN);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumRounds; i++) v_q[i] <= 1'b0;
    end else if (advance) begin
      v_q[0] <= in_acc;
      for (int i = 1; i <= NumRounds; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_q[0] <= in_data_i ^ {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};
    end
  end

  for (genvar k = 1; k <= NumRounds; k++) begin : g_round
    always_ff @(posedge clk_i) begin
      if (advance) begin
        if (4'(k) > nr) begin
          st_q[k] <= st_q[k-1];
        end else begin
          st_q[k] <= aes_round(st_q[k-1], {rk_q[4*k], rk_q[4*k+1], rk_q[4*k+2], rk_q[4*k+3]},
                               4'(k) == nr);
        end
      end
    end
  end

  assign out_valid_o = v_q[NumRounds];
  assign out_data_o  = st_q[NumRounds];

  a_acc_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> sched_q)
    else $error("block accepted without a valid schedule");
  a_ks_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ks_state_q == KS_RUN) |-> in_stall_o)
    else $error("input open during key expansion");
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NumRounds] && out_stall_i) |=> v_q[NumRounds])
    else $error("stalled result lost");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ks_state_q == KS_RUN) |-> (cnt_q <= ks_last))
    else $error("schedule counter overran");

endmodule
